// ===== rtl/pqd_pkg.sv =====
`timescale 1ns / 1ps

package pqd_pkg;

  localparam int MAX_WIDTH   = 1024;
  localparam int PAL_ENTRIES = 256;
  localparam int ERR_DEPTH   = MAX_WIDTH + 2;
  localparam int ERR_AW      = $clog2(ERR_DEPTH);
  localparam int COL_W       = $clog2(MAX_WIDTH);
  localparam int PAL_AW      = $clog2(PAL_ENTRIES);
  localparam int CH_W        = 18;
  localparam int ENTRY_W     = 3 * CH_W;

  localparam logic [15:0] LFSR_TAPS = 16'hB400;

  localparam logic [1:0] REG_MODE  = 2'd0;
  localparam logic [1:0] REG_WIDTH = 2'd1;
  localparam logic [1:0] REG_AMP   = 2'd2;
  localparam logic [1:0] REG_SEED  = 2'd3;

  localparam logic [1:0] MODE_NONE    = 2'd0;
  localparam logic [1:0] MODE_DIFFUSE = 2'd1;
  localparam logic [1:0] MODE_BAYER   = 2'd2;
  localparam logic [1:0] MODE_NOISE   = 2'd3;

  typedef enum logic [1:0] {
    OP_RIGHT,
    OP_BELOW_LEFT,
    OP_BELOW,
    OP_BELOW_RIGHT
  } diff_op_t;

  typedef enum logic [3:0] {
    S_BOOT,
    S_IDLE,
    S_CLR_IMG,
    S_PREP,
    S_LFSR,
    S_DIV,
    S_RDCUR,
    S_CALC,
    S_SEARCH,
    S_RDBEST,
    S_ERRC,
    S_DRD,
    S_DWR,
    S_FINISH,
    S_CLR_ROW
  } state_t;

  typedef struct packed {
    logic     load;
    logic     new_img;
    logic     pal_wr;
    logic     clr_en;
    logic     clr_both;
    logic     lfsr_step;
    logic     div_start;
    logic     err_rd;
    logic     calc;
    logic     search_start;
    logic     best_rd;
    logic     err_calc;
    logic     diff_rd;
    logic     diff_wr;
    diff_op_t op;
    logic     res_load;
    logic     col_adv;
  } cmd_t;

  typedef struct packed {
    logic [1:0] mode;
    logic       opaque;
    logic       clr_last;
    logic       div_done;
    logic       search_done;
    logic       wrap;
    logic       out_free;
  } status_t;

  function automatic logic [3:0] bayer(input logic [1:0] row, input logic [1:0] col);
    logic [63:0] tbl;
    tbl = {4'd5, 4'd13, 4'd7, 4'd15,
           4'd9, 4'd1, 4'd11, 4'd3,
           4'd6, 4'd14, 4'd4, 4'd12,
           4'd10, 4'd2, 4'd8, 4'd0};
    return tbl[{row, col, 2'b00} +: 4];
  endfunction

  function automatic logic [15:0] lfsr_next(input logic [15:0] s);
    return {1'b0, s[15:1]} ^ (s[0] ? LFSR_TAPS : 16'h0000);
  endfunction

endpackage

// ===== rtl/pqd_ctrl.sv =====
`timescale 1ns / 1ps

module pqd_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            req_valid,
  input  logic            req_type,
  input  logic            new_image,
  output logic            req_stall,
  input  pqd_pkg::status_t sts,
  output pqd_pkg::cmd_t   cmd
);

  pqd_pkg::state_t   state, state_next;
  pqd_pkg::diff_op_t op, op_next;
  logic              accept;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= pqd_pkg::S_BOOT;
      op    <= pqd_pkg::OP_RIGHT;
    end else begin
      state <= state_next;
      op    <= op_next;
    end
  end

  assign req_stall = (state != pqd_pkg::S_IDLE);
  assign accept    = req_valid && (state == pqd_pkg::S_IDLE);

  always_comb begin
    state_next = state;
    op_next    = op;
    cmd        = '0;
    cmd.op     = op;
    unique case (state)
      pqd_pkg::S_BOOT: begin
        cmd.clr_en   = 1'b1;
        cmd.clr_both = 1'b1;
        if (sts.clr_last) state_next = pqd_pkg::S_IDLE;
      end
      pqd_pkg::S_IDLE: begin
        if (accept) begin
          cmd.load = 1'b1;
          if (!req_type) begin
            cmd.pal_wr = 1'b1;
          end else if (new_image) begin
            cmd.new_img = 1'b1;
            state_next  = pqd_pkg::S_CLR_IMG;
          end else begin
            state_next = pqd_pkg::S_PREP;
          end
        end
      end
      pqd_pkg::S_CLR_IMG: begin
        cmd.clr_en   = 1'b1;
        cmd.clr_both = 1'b1;
        if (sts.clr_last) state_next = pqd_pkg::S_PREP;
      end
      pqd_pkg::S_PREP: begin
        if (!sts.opaque) state_next = pqd_pkg::S_FINISH;
        else if (sts.mode == pqd_pkg::MODE_NOISE) state_next = pqd_pkg::S_LFSR;
        else state_next = pqd_pkg::S_RDCUR;
      end
      pqd_pkg::S_LFSR: begin
        cmd.lfsr_step = 1'b1;
        cmd.div_start = 1'b1;
        state_next    = pqd_pkg::S_DIV;
      end
      pqd_pkg::S_DIV: begin
        if (sts.div_done) state_next = pqd_pkg::S_RDCUR;
      end
      pqd_pkg::S_RDCUR: begin
        cmd.err_rd = 1'b1;
        state_next = pqd_pkg::S_CALC;
      end
      pqd_pkg::S_CALC: begin
        cmd.calc         = 1'b1;
        cmd.search_start = 1'b1;
        state_next       = pqd_pkg::S_SEARCH;
      end
      pqd_pkg::S_SEARCH: begin
        if (sts.search_done) begin
          if (sts.mode == pqd_pkg::MODE_DIFFUSE) state_next = pqd_pkg::S_RDBEST;
          else state_next = pqd_pkg::S_FINISH;
        end
      end
      pqd_pkg::S_RDBEST: begin
        cmd.best_rd = 1'b1;
        state_next  = pqd_pkg::S_ERRC;
      end
      pqd_pkg::S_ERRC: begin
        cmd.err_calc = 1'b1;
        op_next      = pqd_pkg::OP_RIGHT;
        state_next   = pqd_pkg::S_DRD;
      end
      pqd_pkg::S_DRD: begin
        cmd.diff_rd = 1'b1;
        state_next  = pqd_pkg::S_DWR;
      end
      pqd_pkg::S_DWR: begin
        cmd.diff_wr = 1'b1;
        if (op == pqd_pkg::OP_BELOW_RIGHT) begin
          state_next = pqd_pkg::S_FINISH;
        end else begin
          op_next    = pqd_pkg::diff_op_t'(op + 2'd1);
          state_next = pqd_pkg::S_DRD;
        end
      end
      pqd_pkg::S_FINISH: begin
        if (sts.out_free) begin
          cmd.res_load = 1'b1;
          cmd.col_adv  = 1'b1;
          state_next   = sts.wrap ? pqd_pkg::S_CLR_ROW : pqd_pkg::S_IDLE;
        end
      end
      pqd_pkg::S_CLR_ROW: begin
        cmd.clr_en = 1'b1;
        if (sts.clr_last) state_next = pqd_pkg::S_IDLE;
      end
      default: state_next = pqd_pkg::S_BOOT;
    endcase
  end

`ifndef ASSERT_OFF
  a_wr_order: assert property (@(posedge clk) disable iff (rst)
    cmd.diff_wr |-> $past(cmd.diff_rd))
    else $error("diffusion write without preceding read");
  a_search_mode: assert property (@(posedge clk) disable iff (rst)
    cmd.search_start |-> sts.opaque)
    else $error("search started for transparent pixel");
  a_finish_free: assert property (@(posedge clk) disable iff (rst)
    cmd.res_load |-> sts.out_free)
    else $error("result overwritten while pending");
`endif

endmodule

// ===== rtl/pqd_dp.sv =====
`timescale 1ns / 1ps

module pqd_dp (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [1:0]            cfg_index,
  input  logic [15:0]           cfg_data,
  input  logic [7:0]            pal_index,
  input  logic [7:0]            red,
  input  logic [7:0]            green,
  input  logic [7:0]            blue,
  input  logic [7:0]            alpha,
  input  pqd_pkg::cmd_t         cmd,
  output pqd_pkg::status_t      sts,
  output logic                  rsp_valid,
  input  logic                  rsp_stall,
  output logic [7:0]            color_index
);

  // configuration
  logic [1:0]  mode;
  logic [10:0] iw;
  logic [6:0]  amp;
  logic [15:0] seed;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= pqd_pkg::MODE_NONE;
      iw   <= 11'd1024;
      amp  <= 7'd16;
      seed <= 16'd1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        pqd_pkg::REG_MODE:  mode <= cfg_data[1:0];
        pqd_pkg::REG_WIDTH: iw   <= cfg_data[10:0];
        pqd_pkg::REG_AMP:   amp  <= cfg_data[6:0];
        pqd_pkg::REG_SEED:  seed <= cfg_data;
        default: ;
      endcase
    end
  end

  // pixel latch
  logic [7:0] pix [3];
  logic       opaque;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      pix[0] <= red;
      pix[1] <= green;
      pix[2] <= blue;
      opaque <= (alpha != 8'd0);
    end
  end

  // position
  logic [pqd_pkg::COL_W-1:0] col;
  logic [1:0]                phase;
  logic                      sel;
  logic [10:0]               wused;
  logic [10:0]               col_inc;
  logic                      wrap;

  assign col_inc = {1'b0, col} + 11'd1;
  always_comb begin
    if (iw == 11'd0) wused = 11'd1;
    else if (iw > 11'(pqd_pkg::MAX_WIDTH)) wused = 11'(pqd_pkg::MAX_WIDTH);
    else wused = iw;
  end
  assign wrap = (col_inc >= wused);

  always_ff @(posedge clk) begin
    if (rst) begin
      col   <= '0;
      phase <= 2'd0;
      sel   <= 1'b0;
    end else if (cmd.new_img) begin
      col   <= '0;
      phase <= 2'd0;
    end else if (cmd.col_adv) begin
      if (wrap) begin
        col   <= '0;
        phase <= phase + 2'd1;
        sel   <= ~sel;
      end else begin
        col <= col_inc[pqd_pkg::COL_W-1:0];
      end
    end
  end

  // noise generator and remainder unit
  logic [15:0] lfsr;
  logic [15:0] lfsr_nxt;
  logic [15:0] dvd;
  logic [7:0]  rem;
  logic [3:0]  div_cnt;
  logic        div_busy;
  logic [8:0]  div_t;

  assign lfsr_nxt = pqd_pkg::lfsr_next(lfsr);
  assign div_t    = {rem, dvd[15]};

  always_ff @(posedge clk) begin
    if (rst) begin
      lfsr     <= 16'd1;
      div_busy <= 1'b0;
      div_cnt  <= 4'd0;
    end else begin
      if (cmd.new_img) lfsr <= (seed == 16'd0) ? 16'd1 : seed;
      else if (cmd.lfsr_step) lfsr <= lfsr_nxt;
      if (cmd.div_start) begin
        div_busy <= 1'b1;
        div_cnt  <= 4'd15;
      end else if (div_busy) begin
        div_cnt <= div_cnt - 4'd1;
        if (div_cnt == 4'd0) div_busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      dvd <= lfsr_nxt;
      rem <= 8'd0;
    end else if (div_busy) begin
      dvd <= {dvd[14:0], 1'b0};
      if (div_t >= {1'b0, amp, 1'b1}) rem <= 8'(div_t - {1'b0, amp, 1'b1});
      else rem <= div_t[7:0];
    end
  end

  // palette memory
  logic [23:0]                palmem [pqd_pkg::PAL_ENTRIES];
  logic [23:0]                pal_q;
  logic [pqd_pkg::PAL_AW-1:0] pal_ra;
  logic [pqd_pkg::PAL_AW-1:0] scnt;
  logic [7:0]                 best;

  assign pal_ra = cmd.best_rd ? best : scnt;

  always_ff @(posedge clk) begin
    if (cmd.pal_wr) palmem[pal_index] <= {red, green, blue};
    pal_q <= palmem[pal_ra];
  end

  // error row memories
  logic [pqd_pkg::ENTRY_W-1:0] emem0 [pqd_pkg::ERR_DEPTH];
  logic [pqd_pkg::ENTRY_W-1:0] emem1 [pqd_pkg::ERR_DEPTH];
  logic [pqd_pkg::ENTRY_W-1:0] eq0, eq1, eq, ewd;
  logic [pqd_pkg::ERR_AW-1:0]  ra, ra_r, clr_cnt;
  logic                        rb, rb_r;
  logic                        we0, we1;
  logic [pqd_pkg::ERR_AW-1:0]  wa;
  logic                        clr_last;

  assign clr_last = (clr_cnt == pqd_pkg::ERR_AW'(pqd_pkg::ERR_DEPTH - 1));

  always_comb begin
    ra = {1'b0, col} + pqd_pkg::ERR_AW'(1);
    rb = sel;
    if (cmd.diff_rd) begin
      unique case (cmd.op)
        pqd_pkg::OP_RIGHT: begin
          ra = {1'b0, col} + pqd_pkg::ERR_AW'(2);
          rb = sel;
        end
        pqd_pkg::OP_BELOW_LEFT: begin
          ra = {1'b0, col};
          rb = ~sel;
        end
        pqd_pkg::OP_BELOW: begin
          ra = {1'b0, col} + pqd_pkg::ERR_AW'(1);
          rb = ~sel;
        end
        pqd_pkg::OP_BELOW_RIGHT: begin
          ra = {1'b0, col} + pqd_pkg::ERR_AW'(2);
          rb = ~sel;
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    if (cmd.clr_en) begin
      wa  = clr_cnt;
      we0 = cmd.clr_both || sel;
      we1 = cmd.clr_both || !sel;
    end else begin
      wa  = ra_r;
      we0 = cmd.diff_wr && !rb_r;
      we1 = cmd.diff_wr && rb_r;
    end
  end

  always_ff @(posedge clk) begin
    if (we0) emem0[wa] <= cmd.clr_en ? '0 : ewd;
    eq0 <= emem0[ra];
  end

  always_ff @(posedge clk) begin
    if (we1) emem1[wa] <= cmd.clr_en ? '0 : ewd;
    eq1 <= emem1[ra];
  end

  always_ff @(posedge clk) begin
    if (cmd.err_rd || cmd.diff_rd) begin
      ra_r <= ra;
      rb_r <= rb;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) clr_cnt <= '0;
    else if (cmd.clr_en) clr_cnt <= clr_last ? '0 : clr_cnt + pqd_pkg::ERR_AW'(1);
  end

  assign eq = rb_r ? eq1 : eq0;

  // dithered channel values
  logic signed [8:0]  offset;
  logic [3:0]         bval;
  logic [11:0]        v16 [3];
  logic signed [19:0] vs  [3];
  logic signed [17:0] ech [3];

  assign bval = pqd_pkg::bayer(phase, col[1:0]);

  always_comb begin
    unique case (mode)
      pqd_pkg::MODE_BAYER: offset = $signed({4'b0, bval, 1'b0}) - 9'sd15;
      pqd_pkg::MODE_NOISE: offset = $signed({1'b0, rem}) - $signed({2'b0, amp});
      default:             offset = 9'sd0;
    endcase
  end

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      ech[c] = $signed(eq[(2-c)*pqd_pkg::CH_W +: pqd_pkg::CH_W]);
      vs[c]  = $signed({8'b0, pix[c], 4'b0}) + $signed({{7{offset[8]}}, offset, 4'b0})
             + ((mode == pqd_pkg::MODE_DIFFUSE) ? $signed({{2{ech[c][17]}}, ech[c]})
                                                : 20'sd0);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.calc) begin
      for (int c = 0; c < 3; c++) begin
        if (vs[c] < 20'sd0) v16[c] <= 12'd0;
        else if (vs[c] > 20'sd4080) v16[c] <= 12'd4080;
        else v16[c] <= vs[c][11:0];
      end
    end
  end

  // nearest-entry search, three stages
  logic        srun, v1, v2;
  logic [7:0]  idx1, idx2;
  logic [15:0] sq [3];
  logic [17:0] bdist;
  logic [17:0] dsum;
  logic signed [8:0]  dd [3];
  logic signed [17:0] dsq [3];
  logic        search_done;

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      dd[c]  = $signed({1'b0, v16[c][11:4]}) - $signed({1'b0, pal_q[(2-c)*8 +: 8]});
      dsq[c] = dd[c] * dd[c];
    end
  end

  assign dsum        = {2'b0, sq[0]} + {2'b0, sq[1]} + {2'b0, sq[2]};
  assign search_done = v2 && (idx2 == 8'(pqd_pkg::PAL_ENTRIES - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      srun <= 1'b0;
      v1   <= 1'b0;
      v2   <= 1'b0;
      scnt <= '0;
    end else begin
      v1 <= srun;
      v2 <= v1;
      if (cmd.search_start) begin
        srun <= 1'b1;
        scnt <= '0;
      end else if (srun) begin
        scnt <= scnt + pqd_pkg::PAL_AW'(1);
        if (scnt == pqd_pkg::PAL_AW'(pqd_pkg::PAL_ENTRIES - 1)) srun <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    idx1 <= 8'(scnt);
    idx2 <= idx1;
    for (int c = 0; c < 3; c++) sq[c] <= dsq[c][15:0];
    if (cmd.load) begin
      best <= 8'hFF;
    end else if (cmd.search_start) begin
      bdist <= '1;
    end else if (v2 && (dsum < bdist)) begin
      bdist <= dsum;
      best  <= idx2;
    end
  end

  // error diffusion
  logic signed [13:0] err [3];
  logic [2:0]         kw;

  function automatic logic signed [13:0] share16(input logic signed [13:0] e,
                                                 input logic [2:0] k);
    logic signed [17:0] t;
    t = $signed({{4{e[13]}}, e}) * $signed({15'b0, k}) + 18'sd8;
    return t[17:4];
  endfunction

  always_comb begin
    unique case (cmd.op)
      pqd_pkg::OP_RIGHT:       kw = 3'd7;
      pqd_pkg::OP_BELOW_LEFT:  kw = 3'd3;
      pqd_pkg::OP_BELOW:       kw = 3'd5;
      pqd_pkg::OP_BELOW_RIGHT: kw = 3'd1;
      default:                 kw = 3'd0;
    endcase
  end

  always_comb begin
    logic signed [13:0] s;
    for (int c = 0; c < 3; c++) begin
      s = share16(err[c], kw);
      ewd[(2-c)*pqd_pkg::CH_W +: pqd_pkg::CH_W] = ech[c] + $signed({{4{s[13]}}, s});
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.err_calc) begin
      for (int c = 0; c < 3; c++)
        err[c] <= $signed({2'b0, v16[c]}) - $signed({2'b0, pal_q[(2-c)*8 +: 8], 4'b0});
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) rsp_valid <= 1'b0;
    else if (cmd.res_load) rsp_valid <= 1'b1;
    else if (!rsp_stall) rsp_valid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (cmd.res_load) color_index <= best;
  end

  assign sts.mode        = mode;
  assign sts.opaque      = opaque;
  assign sts.clr_last    = clr_last;
  assign sts.div_done    = div_busy && (div_cnt == 4'd0);
  assign sts.search_done = search_done;
  assign sts.wrap        = wrap;
  assign sts.out_free    = !rsp_valid || !rsp_stall;

`ifndef ASSERT_OFF
  a_pal_wr_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.pal_wr |-> !srun && !v1 && !v2)
    else $error("palette written during search");
  a_div_free: assert property (@(posedge clk) disable iff (rst)
    cmd.div_start |-> !div_busy)
    else $error("remainder unit restarted while busy");
  a_search_end: assert property (@(posedge clk) disable iff (rst)
    search_done |=> !srun && !v1 && !v2)
    else $error("search pipeline not drained");
`endif

endmodule

// ===== rtl/palette_quantizer_with_dither.sv =====
`timescale 1ns / 1ps
// palette write: accepted while idle, no result
// pixel: transparent pixels skip the search; opaque pixels are matched by a scan of the 256-entry palette
// noise mode adds the remainder steps, error diffusion adds the error calculation and a read and write per neighbour
// row end adds a clearing pass over one error row, new image a clearing pass over both error rows
// synchronous reset; a clearing pass over both error rows follows reset before the first transaction
module palette_quantizer_with_dither (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        req_valid,
  output logic        req_stall,
  input  logic        req_type,
  input  logic [7:0]  pal_index,
  input  logic [7:0]  red,
  input  logic [7:0]  green,
  input  logic [7:0]  blue,
  input  logic [7:0]  alpha,
  input  logic        new_image,
  output logic        rsp_valid,
  input  logic        rsp_stall,
  output logic [7:0]  color_index
);

  pqd_pkg::cmd_t    cmd;
  pqd_pkg::status_t sts;

  pqd_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_type  (req_type),
    .new_image (new_image),
    .req_stall (req_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  pqd_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .pal_index   (pal_index),
    .red         (red),
    .green       (green),
    .blue        (blue),
    .alpha       (alpha),
    .cmd         (cmd),
    .sts         (sts),
    .rsp_valid   (rsp_valid),
    .rsp_stall   (rsp_stall),
    .color_index (color_index)
  );

endmodule
